// File: sv/dmps_pkg.sv
// dmps_pkg: constants and field widths shared by the priority sorter files
// no dependencies; taken in by the interfaces and the top level

package dmps_pkg;

   localparam int FIELD_TIME_W = 32;
   localparam int TASK_IDX_W   = 5;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_IMPORTANT_FIRST = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY_IS_DEADLINE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT_POLICY    = 2'd2;

   localparam logic [1:0] POLICY_NONE     = 2'd0;
   localparam logic [1:0] POLICY_SMALLEST = 2'd1;
   localparam logic [1:0] POLICY_LARGEST  = 2'd2;

endpackage

// File: sv/dmps_ifs.sv
// dmps_ifs: valid/ready channel interfaces for task words, result words and csr writes
// depends on dmps_pkg for field widths

interface dmps_req_if import dmps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    task_important;
   logic [FIELD_TIME_W-1:0] task_deadline;
   logic [FIELD_TIME_W-1:0] task_period;
   logic [FIELD_TIME_W-1:0] avg_exec_time;
   logic                    has_limit_options;
   logic [FIELD_TIME_W-1:0] smallest_limit;
   logic [FIELD_TIME_W-1:0] largest_limit;
   logic                    last_task;

   modport source (output valid, task_important, task_deadline, task_period, avg_exec_time,
                   has_limit_options, smallest_limit, largest_limit, last_task,
                   input ready);
   modport sink (input valid, task_important, task_deadline, task_period, avg_exec_time,
                 has_limit_options, smallest_limit, largest_limit, last_task,
                 output ready);
endinterface

interface dmps_rsp_if import dmps_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TASK_IDX_W-1:0]   task_index;
   logic [FIELD_TIME_W-1:0] chosen_limit;
   logic                    limit_valid;
   logic                    last_result;
   logic                    tasks_dropped;

   modport source (output valid, task_index, chosen_limit, limit_valid, last_result,
                   tasks_dropped, input ready);
   modport sink (input valid, task_index, chosen_limit, limit_valid, last_result,
                 tasks_dropped, output ready);
endinterface

interface dmps_csr_if import dmps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// File: sv/dmps_store.sv
// dmps_store: task entry memory, one write port and one registered read port
// no dependencies

module dmps_store #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 98
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/dmps_cmp.sv
// dmps_cmp: shared priority compare, true when task a ranks strictly ahead of task b
// no dependencies

module dmps_cmp #(
   parameter int KEY_W = 32,
   parameter int IDX_W = 5
) (
   input  logic             important_first,
   input  logic             a_imp,
   input  logic [KEY_W-1:0] a_key,
   input  logic [KEY_W-1:0] a_avg,
   input  logic [IDX_W-1:0] a_idx,
   input  logic             b_imp,
   input  logic [KEY_W-1:0] b_key,
   input  logic [KEY_W-1:0] b_avg,
   input  logic [IDX_W-1:0] b_idx,
   output logic             a_first
);

   always_comb begin
      if (important_first && (a_imp != b_imp)) begin
         a_first = a_imp;
      end else if (a_key != b_key) begin
         a_first = a_key < b_key;
      end else if (a_avg != b_avg) begin
         a_first = a_avg < b_avg;
      end else begin
         a_first = a_idx < b_idx;
      end
   end

endmodule

// File: sv/deadline_monotonic_priority_sort.sv
// deadline_monotonic_priority_sort: task set loader and priority-order emitter
// depends on dmps_pkg, dmps_ifs, dmps_store and dmps_cmp
//
// req_chan takes one task word per accepted handshake; ready is high
// only while the block is loading. a word with last_task set closes the set.
// the set of n stored tasks then leaves on rsp_chan as n words, highest priority first.
// each rank is found by a scan of the entry memory through the one compare unit:
// the scan reads every stored entry, one step waits out the registered read
// and one hand-over step puts the winner into the result register.
// csr_chan is always ready; a write is registered in the cycle it is accepted.
// tasks beyond MAX_TASKS are dropped and every result of that set flags tasks_dropped.
// reset clears the registers to their defaults, the task count and the drop flag.
// the result word is held in an output register; when the receiver stalls, the word
// holds and the next scan waits at its hand-over until the register frees.

module deadline_monotonic_priority_sort import dmps_pkg::*; #(
   parameter int MAX_TASKS = 32,
   parameter int TIME_BITS = 32
) (
   input logic      clock,
   input logic      reset,
   dmps_req_if.sink req_chan,
   dmps_rsp_if.source rsp_chan,
   dmps_csr_if.sink csr_chan
);

   localparam int IDX_W   = $clog2(MAX_TASKS);
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int STORE_W = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;

   typedef struct packed {
      logic               imp;
      logic [STORE_W-1:0] key;
      logic [STORE_W-1:0] avg;
      logic [STORE_W-1:0] lim;
      logic               lim_valid;
   } entry_type;

   typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_DRAIN, ST_PUT} state_type;

   state_type              state_ff, state_in;
   logic                   imp_first_ff, imp_first_in;
   logic                   key_dl_ff, key_dl_in;
   logic [1:0]             policy_ff, policy_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic [IDX_W-1:0]       rank_ff, rank_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   best_vld_ff, best_vld_in;
   entry_type              best_ff, best_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [MAX_TASKS-1:0]   emitted_ff, emitted_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TASK_IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [FIELD_TIME_W-1:0] rsp_limit_ff, rsp_limit_in;
   logic                   rsp_lim_vld_ff, rsp_lim_vld_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   entry_type        wr_entry;
   entry_type        rd_entry;
   logic             wr_en;
   logic             cand_first;
   logic [IDX_W-1:0] last_idx;
   logic             has_room;

   assign last_idx = IDX_W'(count_ff - CNT_W'(1));
   assign has_room = count_ff < CNT_W'(MAX_TASKS);

   // entry as stored: of the two keys and the two limits, only the chosen ones are kept
   always_comb begin
      wr_entry.imp = req_chan.task_important;
      wr_entry.avg = req_chan.avg_exec_time[STORE_W-1:0];
      if (key_dl_ff) begin
         wr_entry.key = req_chan.task_deadline[STORE_W-1:0];
      end else begin
         wr_entry.key = req_chan.task_period[STORE_W-1:0];
      end
      if ((policy_ff == POLICY_NONE) || !req_chan.has_limit_options) begin
         wr_entry.lim_valid = 1'b0;
         wr_entry.lim       = '0;
      end else if (policy_ff == POLICY_SMALLEST) begin
         wr_entry.lim_valid = 1'b1;
         wr_entry.lim       = req_chan.smallest_limit[STORE_W-1:0];
      end else begin
         wr_entry.lim_valid = 1'b1;
         wr_entry.lim       = req_chan.largest_limit[STORE_W-1:0];
      end
   end

   dmps_store #(
      .DEPTH  (MAX_TASKS),
      .DATA_W ($bits(entry_type))
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (scan_ff),
      .rd_data (rd_entry)
   );

   dmps_cmp #(
      .KEY_W (STORE_W),
      .IDX_W (IDX_W)
   ) u_cmp (
      .important_first (imp_first_ff),
      .a_imp           (rd_entry.imp),
      .a_key           (rd_entry.key),
      .a_avg           (rd_entry.avg),
      .a_idx           (cmp_idx_ff),
      .b_imp           (best_ff.imp),
      .b_key           (best_ff.key),
      .b_avg           (best_ff.avg),
      .b_idx           (best_idx_ff),
      .a_first         (cand_first)
   );

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      imp_first_in   = imp_first_ff;
      key_dl_in      = key_dl_ff;
      policy_in      = policy_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      scan_in        = scan_ff;
      rank_in        = rank_ff;
      cmp_vld_in     = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      best_vld_in    = best_vld_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      emitted_in     = emitted_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_limit_in   = rsp_limit_ff;
      rsp_lim_vld_in = rsp_lim_vld_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_drop_in    = rsp_drop_ff;
      wr_en          = 1'b0;

      if (csr_chan.valid) begin
         case (csr_chan.addr)
            REG_IMPORTANT_FIRST: imp_first_in = csr_chan.data[0];
            REG_KEY_IS_DEADLINE: key_dl_in    = csr_chan.data[0];
            REG_LIMIT_POLICY:    policy_in    = csr_chan.data[1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // running minimum over the entry read back last cycle
      if (cmp_vld_ff && !emitted_ff[cmp_idx_ff] && (!best_vld_ff || cand_first)) begin
         best_vld_in = 1'b1;
         best_in     = rd_entry;
         best_idx_in = cmp_idx_ff;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               if (has_room) begin
                  wr_en    = 1'b1;
                  count_in = CNT_W'(count_ff + CNT_W'(1));
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_task) begin
                  state_in    = ST_SCAN;
                  scan_in     = '0;
                  rank_in     = '0;
                  best_vld_in = 1'b0;
                  emitted_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = scan_ff;
            if (scan_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = IDX_W'(scan_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_index_in            = TASK_IDX_W'(best_idx_ff);
               rsp_limit_in            = FIELD_TIME_W'(best_ff.lim);
               rsp_lim_vld_in          = best_ff.lim_valid;
               rsp_last_in             = (rank_ff == last_idx);
               rsp_drop_in             = ovf_ff;
               emitted_in[best_idx_ff] = 1'b1;
               best_vld_in             = 1'b0;
               if (rank_ff == last_idx) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  state_in = ST_SCAN;
                  rank_in  = IDX_W'(rank_ff + 1'b1);
                  scan_in  = '0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         imp_first_ff <= 1'b0;
         key_dl_ff    <= 1'b1;
         policy_ff    <= POLICY_NONE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         imp_first_ff <= imp_first_in;
         key_dl_ff    <= key_dl_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         cmp_vld_ff   <= cmp_vld_in;
         best_vld_ff  <= best_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff        <= scan_in;
      rank_ff        <= rank_in;
      cmp_idx_ff     <= cmp_idx_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      emitted_ff     <= emitted_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_limit_ff   <= rsp_limit_in;
      rsp_lim_vld_ff <= rsp_lim_vld_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_drop_ff    <= rsp_drop_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.task_index    = rsp_index_ff;
   assign rsp_chan.chosen_limit  = rsp_limit_ff;
   assign rsp_chan.limit_valid   = rsp_lim_vld_ff;
   assign rsp_chan.last_result   = rsp_last_ff;
   assign rsp_chan.tasks_dropped = rsp_drop_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond store depth");

   a_put_has_winner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUT) |-> (best_vld_ff && !emitted_ff[best_idx_ff]))
      else $error("hand-over without a fresh winner");

   a_rank_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> ((CNT_W'(rank_ff) < count_ff) && (count_ff != '0)))
      else $error("rank beyond stored set");

   a_emit_after_put: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_PUT))
      else $error("result word raised outside hand-over");

endmodule
